@@ src/u8se_pkg.sv @@
// u8se_pkg: shared types, constants and escape helpers for the utf-8 sanitizer
// used by u8se_front, u8se_queue, u8se_back and utf8_sanitize_escape
// no dependencies
package u8se_pkg;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_RAW  = 2'd0;
  localparam mode_t MODE_JSON = 2'd1;
  localparam mode_t MODE_HTML = 2'd2;

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] SURR_LO     = 21'h00D800;
  localparam logic [20:0] SURR_HI     = 21'h00DFFF;
  localparam logic [20:0] MIN_THREE   = 21'h000800;
  localparam logic [20:0] MIN_FOUR    = 21'h010000;
  localparam logic [7:0]  LEAD_MIN    = 8'hC2;
  localparam logic [7:0]  LEAD_MAX    = 8'hF4;

  typedef logic [5:0][7:0] str6_t;
  localparam str6_t ENT_AMP  = {"&amp;", 8'h00};
  localparam str6_t ENT_LT   = {"&lt;", 16'h0000};
  localparam str6_t ENT_GT   = {"&gt;", 16'h0000};
  localparam str6_t ENT_QUOT = "&quot;";
  localparam str6_t ENT_APOS = {"&#39;", 8'h00};

  // one decoded input word turned into output work
  typedef struct packed {
    logic [3:0][7:0] seq;       // tail bytes, entry 0 first
    logic [2:0]      seq_len;   // number of tail bytes
    logic [3:0]      repl3;     // replacement bytes ahead of the tail (3 per char)
    logic [3:0]      ntot;      // repl3 + seq_len
    logic            last_str;  // input word closed the string
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] repl_byte(input logic [1:0] pos);
    case (pos)
      2'd0:    repl_byte = REPL_B0;
      2'd1:    repl_byte = REPL_B1;
      default: repl_byte = REPL_B2;
    endcase
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) hex_digit = 8'h30 + {4'd0, n};
    else hex_digit = 8'h57 + {4'd0, n};
  endfunction

  function automatic logic [2:0] lead_length(input logic [7:0] c);
    if (c >= LEAD_MIN && c <= 8'hDF) lead_length = 3'd2;
    else if (c >= 8'hE0 && c <= 8'hEF) lead_length = 3'd3;
    else if (c >= 8'hF0 && c <= LEAD_MAX) lead_length = 3'd4;
    else lead_length = 3'd0;
  endfunction

  function automatic logic html_ctrl(input logic [7:0] b);
    html_ctrl = (b < 8'h20) && !(b inside {8'h09, 8'h0A, 8'h0D});
  endfunction

  // number of output bytes one cleaned byte expands to
  function automatic logic [2:0] esc_len(input logic [7:0] b, input mode_t mode);
    case (mode)
      MODE_JSON: begin
        if (b == "\"" || b == "\\") esc_len = 3'd2;
        else if (b < 8'h20) esc_len = 3'd6;
        else esc_len = 3'd1;
      end
      MODE_HTML: begin
        case (b)
          "&":     esc_len = 3'd5;
          "<":     esc_len = 3'd4;
          ">":     esc_len = 3'd4;
          "\"":    esc_len = 3'd6;
          "'":     esc_len = 3'd5;
          default: esc_len = html_ctrl(b) ? 3'd3 : 3'd1;
        endcase
      end
      default: esc_len = 3'd1;
    endcase
  endfunction

  // output byte at position idx of the expansion of b
  function automatic logic [7:0] esc_char(input logic [7:0] b, input mode_t mode,
                                          input logic [2:0] idx);
    case (mode)
      MODE_JSON: begin
        if (b == "\"" || b == "\\") esc_char = (idx == 3'd0) ? 8'h5C : b;
        else if (b < 8'h20) begin
          case (idx)
            3'd0:    esc_char = "\\";
            3'd1:    esc_char = "u";
            3'd2:    esc_char = "0";
            3'd3:    esc_char = "0";
            3'd4:    esc_char = hex_digit(b[7:4]);
            default: esc_char = hex_digit(b[3:0]);
          endcase
        end else esc_char = b;
      end
      MODE_HTML: begin
        case (b)
          "&":     esc_char = ENT_AMP[3'd5 - idx];
          "<":     esc_char = ENT_LT[3'd5 - idx];
          ">":     esc_char = ENT_GT[3'd5 - idx];
          "\"":    esc_char = ENT_QUOT[3'd5 - idx];
          "'":     esc_char = ENT_APOS[3'd5 - idx];
          default: esc_char = html_ctrl(b) ? repl_byte(idx[1:0]) : b;
        endcase
      end
      default: esc_char = b;
    endcase
  endfunction

endpackage

@@ src/u8se_front.sv @@
// u8se_front: accepts input words, tracks the held utf-8 sequence, emits work commands
// depends on u8se_pkg
module u8se_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_end,
  input  u8se_pkg::q_stat_t q_stat,
  output logic            push,
  output u8se_pkg::cmd_t  cmd
);
  import u8se_pkg::*;

  logic [7:0]  held_bytes [3];
  logic [1:0]  held_count;
  logic [2:0]  expected_length;
  logic [20:0] code_point_acc;

  logic        accept;
  logic        cont;
  logic        fresh;
  logic        hold_ext;
  logic        hold_new;
  logic        cp_ok;
  logic [20:0] acc_shift;
  logic [20:0] acc_lead;
  logic [2:0]  repl;
  logic [2:0]  lead_len;
  logic [2:0]  held_plus;
  logic [3:0]  repl3;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cont      = (in_byte[7:6] == 2'b10);
    acc_shift = {code_point_acc[14:0], in_byte[5:0]};
    held_plus = {1'b0, held_count} + 3'd1;
    cp_ok     = (acc_shift <= CP_MAX)
             && !(acc_shift >= SURR_LO && acc_shift <= SURR_HI)
             && !(expected_length == 3'd3 && acc_shift < MIN_THREE)
             && !(expected_length == 3'd4 && acc_shift < MIN_FOUR);
    lead_len  = lead_length(in_byte);
    fresh     = 1'b1;
    hold_ext  = 1'b0;
    hold_new  = 1'b0;
    repl      = 3'd0;
    cmd.seq   = {4{in_byte}};
    cmd.seq_len = 3'd0;
    if (held_count != 2'd0) begin
      if (cont) begin
        fresh = 1'b0;
        if (held_plus == expected_length) begin
          if (cp_ok) begin
            cmd.seq_len = held_plus;
            for (int i = 0; i < 3; i++) begin
              if (2'(i) < held_count) cmd.seq[i] = held_bytes[i];
            end
          end else begin
            repl = expected_length;
          end
        end else if (in_end || held_count == 2'd3) begin
          repl = held_plus;
        end else begin
          hold_ext = 1'b1;
        end
      end else begin
        repl = {1'b0, held_count};
      end
    end
    if (fresh) begin
      if (!in_byte[7]) cmd.seq_len = 3'd1;
      else if (lead_len == 3'd0 || in_end) repl = repl + 3'd1;
      else hold_new = 1'b1;
    end
    case (lead_len)
      3'd2:    acc_lead = {16'd0, in_byte[4:0]};
      3'd3:    acc_lead = {17'd0, in_byte[3:0]};
      default: acc_lead = {18'd0, in_byte[2:0]};
    endcase
    repl3        = {repl, 1'b0} + {1'b0, repl};
    cmd.repl3    = repl3;
    cmd.ntot     = repl3 + {1'b0, cmd.seq_len};
    cmd.last_str = in_end;
    push         = accept && (repl != 3'd0 || cmd.seq_len != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= 2'd0;
      expected_length <= 3'd0;
      code_point_acc  <= 21'd0;
    end else if (accept) begin
      if (hold_ext) begin
        held_count     <= held_count + 2'd1;
        code_point_acc <= acc_shift;
      end else if (hold_new) begin
        held_count      <= 2'd1;
        expected_length <= lead_len;
        code_point_acc  <= acc_lead;
      end else begin
        held_count      <= 2'd0;
        expected_length <= 3'd0;
        code_point_acc  <= 21'd0;
      end
    end
  end

  // held store has no reset, only entries below held_count are read
  always_ff @(posedge clk) begin
    if (accept) begin
      if (hold_ext) held_bytes[held_count] <= in_byte;
      else if (hold_new) held_bytes[0] <= in_byte;
    end
  end

endmodule

@@ src/u8se_queue.sv @@
// u8se_queue: small fifo of work commands between front and back
// depends on u8se_pkg
module u8se_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8se_pkg::cmd_t    wr_cmd,
  input  logic              pop,
  output u8se_pkg::cmd_t    head,
  output u8se_pkg::q_stat_t stat
);
  import u8se_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_cmd;
  end

endmodule

@@ src/u8se_back.sv @@
// u8se_back: expands the head command into escaped output words, one per cycle while m_tready does not stall it
// depends on u8se_pkg
module u8se_back (
  input  logic                clk,
  input  logic                rst,
  input  u8se_pkg::mode_t     mode,
  input  u8se_pkg::cmd_t      head,
  input  u8se_pkg::q_stat_t   q_stat,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast,
  output logic                m_tuser
);
  import u8se_pkg::*;

  logic [3:0] cidx;
  logic [1:0] rphase;
  logic [2:0] eidx;

  logic       step;
  logic       in_repl;
  logic [3:0] tdiff;
  logic [7:0] cbyte;
  logic [2:0] elen;
  logic       last_c;
  logic       last_all;

  always_comb begin
    step     = !q_stat.empty && (!m_tvalid || m_tready);
    in_repl  = (cidx < head.repl3);
    tdiff    = cidx - head.repl3;
    cbyte    = in_repl ? repl_byte(rphase) : head.seq[tdiff[1:0]];
    elen     = esc_len(cbyte, mode);
    last_c   = (eidx == elen - 3'd1);
    last_all = last_c && (cidx == head.ntot - 4'd1);
    pop      = step && last_all;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      cidx     <= 4'd0;
      rphase   <= 2'd0;
      eidx     <= 3'd0;
    end else if (step) begin
      m_tvalid <= 1'b1;
      if (last_all) begin
        cidx   <= 4'd0;
        rphase <= 2'd0;
        eidx   <= 3'd0;
      end else if (last_c) begin
        eidx <= 3'd0;
        cidx <= cidx + 4'd1;
        if (in_repl) rphase <= (rphase == 2'd2) ? 2'd0 : rphase + 2'd1;
      end else begin
        eidx <= eidx + 3'd1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= esc_char(cbyte, mode, eidx);
      m_tlast <= last_all;
      m_tuser <= last_all && head.last_str;
    end
  end

endmodule

@@ src/utf8_sanitize_escape.sv @@
// utf8_sanitize_escape: top level of the utf-8 sanitizer with json/html escaping
// depends on u8se_pkg, u8se_front, u8se_queue, u8se_back
//
// usage:
//   s_* carries raw string bytes; s_tlast marks the final byte of a string.
//   m_* carries cleaned and escaped output words; m_tlast marks the last word
//   caused by one input word, m_tuser the last word of the whole string.
//   cfg_we/cfg_wdata write escape_mode (0 raw, 1 json, 2 html, 3 acts as raw);
//   write it only while the block is idle.
// timing:
//   the front decodes one input word per cycle and pushes a command into a
//   QUEUE_DEPTH-entry fifo; s_tready drops only while that fifo is full.
//   the back turns the head command into output words at one per cycle while
//   m_tready does not stall it; an input word expands to n output words (n is 0
//   to 15). the first output word of an input is registered in the fifo and then
//   in the output register.
//   a byte that only extends a held sequence produces no output.
// reset and stall:
//   rst (synchronous) empties the fifo, drops the held sequence and sets raw
//   mode. when m_tready is low the output word holds, the back stops, and the
//   front keeps taking input until the fifo fills.
module utf8_sanitize_escape #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  u8se_pkg::mode_t      cfg_wdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // in_byte[7:0]
  input  logic                 s_tlast,   // in_end
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // out_byte[7:0]
  output logic                 m_tlast,   // run_last
  output logic                 m_tuser    // string_done
);
  import u8se_pkg::*;

  mode_t   escape_mode;
  cmd_t    f_cmd;
  cmd_t    q_head;
  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;

  // mode register; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) escape_mode <= MODE_RAW;
    else if (cfg_we) escape_mode <= cfg_wdata;
  end

  // front: utf-8 decode and hold
  u8se_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_end   (s_tlast),
    .q_stat   (q_stat),
    .push     (q_push),
    .cmd      (f_cmd)
  );

  // decoupling fifo
  u8se_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_cmd (f_cmd),
    .pop    (q_pop),
    .head   (q_head),
    .stat   (q_stat)
  );

  // back: escaping and output register
  u8se_back u_back (
    .clk      (clk),
    .rst      (rst),
    .mode     (escape_mode),
    .head     (q_head),
    .q_stat   (q_stat),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // fifo flags never both set
  a_flags_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("fifo reports full and empty together");

  // front never pushes into a full fifo
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("push into full fifo");

  // end of string always closes a run
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("string_done without run_last");

  // output is empty after reset
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule
